FILE: hw/rtl/tccw_pkg.sv
package tccw_pkg;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int COL_W       = $clog2(COLUMNS);
   localparam int ROW_W       = $clog2(ROWS);
   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int INDEX_W     = 11;
   localparam int POS_W       = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;

   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd15;

   localparam addr_type LAST_CELL     = addr_type'(CELL_COUNT - 1);
   localparam addr_type LAST_ROW_BASE = addr_type'((ROWS - 1) * COLUMNS);
   localparam addr_type COLUMNS_ADDR  = addr_type'(COLUMNS);
   localparam col_type  COL_LAST      = col_type'(COLUMNS - 1);
   localparam row_type  ROW_LAST      = row_type'(ROWS - 1);

   typedef enum logic [2:0] {
      OP_GLYPH,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_SCROLL,
      ST_READ
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [INDEX_W-1:0]  cell_index;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hw/rtl/tccw_ram.sv
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/tccw_front.sv
module tccw_front (
   input  logic                           start,
   output logic                           busy,
   input  logic [tccw_pkg::KIND_W-1:0]    req_kind,
   input  logic [tccw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tccw_pkg::INDEX_W-1:0]   req_cell_index,
   input  tccw_pkg::queue_status_type     q_status,
   input  logic                           init_busy,
   output logic                           push,
   output tccw_pkg::cmd_type              cmd
);
   import tccw_pkg::*;

   assign busy = q_status.full || init_busy;
   assign push = start && !busy;

   always_comb begin
      cmd.char_code  = req_char_code;
      cmd.cell_index = req_cell_index;
      unique case (req_kind)
         KIND_PUT: begin
            unique case (req_char_code)
               CH_NEWLINE:   cmd.op = OP_NEWLINE;
               CH_BACKSPACE: cmd.op = OP_BACKSPACE;
               default:      cmd.op = OP_GLYPH;
            endcase
         end
         KIND_CLEAR: cmd.op = OP_CLEAR;
         KIND_READ: begin
            if (32'(req_cell_index) < CELL_COUNT) begin
               cmd.op = OP_READ;
            end else begin
               cmd.op = OP_NOP;
            end
         end
         default: cmd.op = OP_NOP;
      endcase
   end

endmodule

FILE: hw/rtl/tccw_queue.sv
module tccw_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tccw_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output tccw_pkg::cmd_type          head_cmd,
   output tccw_pkg::queue_status_type status
);
   import tccw_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/tccw_back.sv
module tccw_back (
   input  logic                           clock,
   input  logic                           reset,
   input  tccw_pkg::cmd_type              head_cmd,
   input  tccw_pkg::queue_status_type     q_status,
   output logic                           pop,
   output logic                           init_busy,
   input  logic                           csr_valid,
   input  logic [tccw_pkg::ATTR_W-1:0]    csr_text_attribute,
   output logic                           rsp_strobe,
   output logic [tccw_pkg::POS_W-1:0]     rsp_cursor_pos,
   output logic [tccw_pkg::CHAR_W-1:0]    rsp_cell_glyph,
   output logic [tccw_pkg::ATTR_W-1:0]    rsp_cell_attr
);
   import tccw_pkg::*;

   localparam logic [ADDR_W:0] CELL_COUNT_X = (ADDR_W + 1)'(CELL_COUNT);

   back_state_type        state_ff, state_in;
   addr_type              sweep_ff, sweep_in;
   col_type               scroll_ff, scroll_in;
   addr_type              base_ff, base_in;
   col_type               col_ff, col_in;
   row_type               row_ff, row_in;
   addr_type              lin_ff, lin_in;
   logic [ATTR_W-1:0]     attr_ff, attr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [CHAR_W-1:0]     rsp_glyph_ff, rsp_glyph_in;
   logic [ATTR_W-1:0]     rsp_attr_ff, rsp_attr_in;

   logic                  mem_we;
   addr_type              mem_waddr;
   logic [CELL_W-1:0]     mem_wdata;
   logic                  mem_re;
   addr_type              mem_raddr;
   logic [CELL_W-1:0]     mem_rdata;
   logic [CELL_W-1:0]     blank;
   addr_type              row_start;

   function automatic addr_type phys_addr(input addr_type lin, input addr_type base);
      logic [ADDR_W:0] sum;
      sum = {1'b0, lin} + {1'b0, base};
      if (sum >= CELL_COUNT_X) begin
         sum = sum - CELL_COUNT_X;
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign blank     = {attr_ff, CH_SPACE};
   assign row_start = lin_ff - addr_type'(col_ff);
   assign init_busy = (state_ff == ST_INIT);

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      scroll_in    = scroll_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      lin_in       = lin_ff;
      attr_in      = csr_valid ? csr_text_attribute : attr_ff;
      rsp_valid_in = 1'b0;
      rsp_glyph_in = '0;
      rsp_attr_in  = '0;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = blank;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = {RESET_ATTR, CH_SPACE};
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + addr_type'(1);
            end
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            if (sweep_ff == LAST_CELL) begin
               sweep_in     = '0;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               sweep_in = sweep_ff + addr_type'(1);
            end
         end
         ST_SCROLL: begin
            mem_we    = 1'b1;
            mem_waddr = base_ff + addr_type'(scroll_ff);
            if (scroll_ff == COL_LAST) begin
               scroll_in    = '0;
               base_in      = (base_ff == LAST_ROW_BASE) ? '0 : base_ff + COLUMNS_ADDR;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               scroll_in = scroll_ff + col_type'(1);
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_glyph_in = mem_rdata[CHAR_W-1:0];
            rsp_attr_in  = mem_rdata[CELL_W-1:CHAR_W];
            state_in     = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               unique case (head_cmd.op)
                  OP_GLYPH: begin
                     mem_we    = 1'b1;
                     mem_waddr = phys_addr(lin_ff, base_ff);
                     mem_wdata = {attr_ff, head_cmd.char_code};
                     if (col_ff == COL_LAST) begin
                        col_in = '0;
                        if (row_ff == ROW_LAST) begin
                           lin_in   = row_start;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in       = row_ff + row_type'(1);
                           lin_in       = lin_ff + addr_type'(1);
                           rsp_valid_in = 1'b1;
                        end
                     end else begin
                        col_in       = col_ff + col_type'(1);
                        lin_in       = lin_ff + addr_type'(1);
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_NEWLINE: begin
                     col_in = '0;
                     if (row_ff == ROW_LAST) begin
                        lin_in   = row_start;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in       = row_ff + row_type'(1);
                        lin_in       = row_start + COLUMNS_ADDR;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in    = col_ff - col_type'(1);
                        lin_in    = lin_ff - addr_type'(1);
                        mem_we    = 1'b1;
                        mem_waddr = phys_addr(lin_ff - addr_type'(1), base_ff);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     lin_in   = '0;
                     base_in  = '0;
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  OP_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = phys_addr(addr_type'(head_cmd.cell_index), base_ff);
                     state_in  = ST_READ;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_pos_in = POS_W'(lin_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         scroll_ff    <= '0;
         base_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         lin_ff       <= '0;
         attr_ff      <= RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         scroll_ff    <= scroll_in;
         base_ff      <= base_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         lin_ff       <= lin_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff   <= rsp_pos_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_attr_ff  <= rsp_attr_in;
   end

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_glyph = rsp_glyph_ff;
   assign rsp_cell_attr  = rsp_attr_ff;

   // The linear cursor position always matches its row and column.
   assert property (@(posedge clock) disable iff (reset)
      lin_ff == addr_type'(int'(row_ff) * COLUMNS + int'(col_ff)))
      else $error("cursor position out of step with row and column");

   assert property (@(posedge clock) disable iff (reset)
      (int'(col_ff) < COLUMNS) && (int'(row_ff) < ROWS) && (int'(base_ff) < CELL_COUNT))
      else $error("cursor or screen base out of range");

   // A command leaves the queue only when the executor is free to take it.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE) && !q_status.empty)
      else $error("command taken while executor busy");

   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> int'(mem_waddr) < CELL_COUNT)
      else $error("screen write beyond last cell");

   // The cycle after memory is addressed, a read is in its read state, unanswered.
   assert property (@(posedge clock) disable iff (reset)
      mem_re |=> (state_ff == ST_READ) && !rsp_strobe)
      else $error("read result timing broken");

endmodule

FILE: hw/rtl/text_console_char_writer.sv
// Character-cell text console writer.
// Commands arrive on start with req_kind, req_char_code and req_cell_index; a
// command beat is taken at a rising edge where start is high and busy is low.
// A put prints a glyph at the cursor, or acts on newline and backspace; a
// clear blanks the screen and homes the cursor; a read returns one cell.
// Every command produces exactly one result beat: rsp_strobe is high for one
// cycle with rsp_cursor_pos, rsp_cell_glyph and rsp_cell_attr. The receiver
// cannot stall; results are simply presented.
// The attribute register is written on the csr channel, which is always ready.
// A put that scrolls the screen makes one bottom-row blanking pass through the
// single write port of the screen memory, rows being rotated by a base offset,
// and a clear makes a full blanking pass.
// Sustained throughput is one put per cycle while no scroll, clear or read
// holds the executor; a read holds it in its read state until the cell is
// returned, so no new command is started meanwhile.
// A two-entry command queue separates the front from the executor; busy is
// high while it is full.
// After reset the screen memory is blanked in a pass over all CELL_COUNT cells
// (2000 at 80 by 25) during which busy stays high; csr writes are still taken.
module text_console_char_writer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tccw_pkg::KIND_W-1:0]    req_kind,
   input  logic [tccw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tccw_pkg::INDEX_W-1:0]   req_cell_index,
   output logic                           rsp_strobe,
   output logic [tccw_pkg::POS_W-1:0]     rsp_cursor_pos,
   output logic [tccw_pkg::CHAR_W-1:0]    rsp_cell_glyph,
   output logic [tccw_pkg::ATTR_W-1:0]    rsp_cell_attr,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tccw_pkg::ATTR_W-1:0]    csr_text_attribute
);
   import tccw_pkg::*;

   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;
   logic             init_busy;

   assign csr_ready = 1'b1;

   tccw_front u_front (
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .q_status       (q_status),
      .init_busy      (init_busy),
      .push           (push),
      .cmd            (push_cmd)
   );

   tccw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   tccw_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_cmd           (head_cmd),
      .q_status           (q_status),
      .pop                (pop),
      .init_busy          (init_busy),
      .csr_valid          (csr_valid && csr_ready),
      .csr_text_attribute (csr_text_attribute),
      .rsp_strobe         (rsp_strobe),
      .rsp_cursor_pos     (rsp_cursor_pos),
      .rsp_cell_glyph     (rsp_cell_glyph),
      .rsp_cell_attr      (rsp_cell_attr)
   );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import tccw_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int IDLE_LOW  = 35;
   localparam int IDLE_HIGH = 63;
   localparam int SEGMENTS  = 6;
   localparam int SEGMENT_ITEMS = 255;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAR_W-1:0]  char_code;
      logic [INDEX_W-1:0] cell_index;
   } console_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CHAR_W-1:0] glyph;
      logic [ATTR_W-1:0] attr;
   } cell_report_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = KIND_PUT;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic [INDEX_W-1:0]  req_cell_index = '0;
   logic                rsp_strobe;
   logic [POS_W-1:0]    rsp_cursor_pos;
   logic [CHAR_W-1:0]   rsp_cell_glyph;
   logic [ATTR_W-1:0]   rsp_cell_attr;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ATTR_W-1:0]   csr_text_attribute = '0;

   console_cmd_type     pending_cmds[$];
   cell_report_type     expected_reports[$];
   console_cmd_type     drive_cmd;

   logic [CELL_W-1:0]   screen_model [CELL_COUNT];
   int                  model_col;
   int                  model_row;
   logic [ATTR_W-1:0]   model_attr;

   int                  idle_pct = IDLE_LOW;
   int                  error_count = 0;
   int                  accepted_count = 0;
   int                  checked_count = 0;
   int                  put_count = 0;
   int                  clear_count = 0;
   int                  read_count = 0;
   int                  scroll_count = 0;
   int                  attr_writes = 0;

   text_console_char_writer u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_cursor_pos     (rsp_cursor_pos),
      .rsp_cell_glyph     (rsp_cell_glyph),
      .rsp_cell_attr      (rsp_cell_attr),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void blank_screen_model();
      for (int i = 0; i < CELL_COUNT; i++) begin
         screen_model[i] = {model_attr, CH_SPACE};
      end
   endfunction

   // Moving past the bottom row shifts every row up and blanks the last one.
   function automatic void next_row_model();
      model_row++;
      if (model_row >= ROWS) begin
         for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
         end
         for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
            screen_model[i] = {model_attr, CH_SPACE};
         end
         model_row = ROWS - 1;
         scroll_count++;
      end
   endfunction

   function automatic cell_report_type console_predict(console_cmd_type cmd);
      cell_report_type rep;
      rep = '0;
      case (cmd.kind)
         KIND_PUT: begin
            put_count++;
            if (cmd.char_code == CH_NEWLINE) begin
               model_col = 0;
               next_row_model();
            end else if (cmd.char_code == CH_BACKSPACE) begin
               if (model_col > 0) begin
                  model_col--;
                  screen_model[model_row * COLUMNS + model_col] = {model_attr, CH_SPACE};
               end
            end else begin
               screen_model[model_row * COLUMNS + model_col] = {model_attr, cmd.char_code};
               model_col++;
               if (model_col >= COLUMNS) begin
                  model_col = 0;
                  next_row_model();
               end
            end
         end
         KIND_CLEAR: begin
            clear_count++;
            blank_screen_model();
            model_col = 0;
            model_row = 0;
         end
         KIND_READ: begin
            read_count++;
            if (cmd.cell_index < CELL_COUNT) begin
               rep.glyph = screen_model[cmd.cell_index][CHAR_W-1:0];
               rep.attr  = screen_model[cmd.cell_index][CELL_W-1:CHAR_W];
            end
         end
         default: begin
         end
      endcase
      rep.cursor_pos = POS_W'(model_row * COLUMNS + model_col);
      return rep;
   endfunction

   function automatic void queue_cmd(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] code,
                                     logic [INDEX_W-1:0] index);
      console_cmd_type cmd;
      cmd.kind       = kind;
      cmd.char_code  = code;
      cmd.cell_index = index;
      pending_cmds.push_back(cmd);
   endfunction

   function automatic logic [INDEX_W-1:0] any_index();
      return INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_reports.push_back(console_predict(drive_cmd));
            accepted_count++;
         end
         if (!start || !busy) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               drive_cmd = pending_cmds.pop_front();
               start          <= 1'b1;
               req_kind       <= drive_cmd.kind;
               req_char_code  <= drive_cmd.char_code;
               req_cell_index <= drive_cmd.cell_index;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_check
      cell_report_type want;
      if (!reset && rsp_strobe) begin
         if (expected_reports.size() == 0) begin
            $error("result beat with nothing expected, cursor_pos %0d", rsp_cursor_pos);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            checked_count++;
            if (rsp_cursor_pos !== want.cursor_pos) begin
               $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, rsp_cursor_pos);
               error_count++;
            end
            if (rsp_cell_glyph !== want.glyph) begin
               $error("cell_glyph: expected 0x%02h, got 0x%02h", want.glyph, rsp_cell_glyph);
               error_count++;
            end
            if (rsp_cell_attr !== want.attr) begin
               $error("cell_attr: expected 0x%02h, got 0x%02h", want.attr, rsp_cell_attr);
               error_count++;
            end
         end
      end
   end

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      @(posedge clock);
      csr_valid          <= 1'b1;
      csr_text_attribute <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      model_attr = value;
      attr_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_reports.size() != 0);
   endtask

   // Traffic is built in bursts: text lines, runs of newlines and reads, with some clears
   // and unused-kind commands, so that the cursor regularly reaches the bottom row and long lines wrap.
   task automatic build_traffic(input int target);
      int made;
      int roll;
      int len;
      logic [CHAR_W-1:0] code;
      logic [INDEX_W-1:0] index;
      @(negedge clock);
      made = 0;
      while (made < target) begin
         roll = $urandom_range(0, 999);
         if (roll < 20) begin
            queue_cmd(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)), any_index());
            made++;
         end else if (roll < 50) begin
            queue_cmd(KIND_UNUSED, CHAR_W'($urandom_range(0, 255)), any_index());
         end else if (roll < 250) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 3))
                  0: index = any_index();
                  1: index = INDEX_W'($urandom_range(CELL_COUNT, 2 ** INDEX_W - 1));
                  default: index = INDEX_W'($urandom_range((ROWS - 2) * COLUMNS,
                                                            CELL_COUNT - 1));
               endcase
               queue_cmd(KIND_READ, CHAR_W'($urandom_range(0, 255)), index);
               made++;
            end
         end else if (roll < 400) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               queue_cmd(KIND_PUT, CH_NEWLINE, any_index());
               made++;
            end
         end else begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(60, 170);
            for (int k = 0; k < len; k++) begin
               code = ($urandom_range(0, 24) == 0) ? CH_BACKSPACE
                                                   : CHAR_W'($urandom_range(0, 255));
               queue_cmd(KIND_PUT, code, any_index());
               made++;
            end
            if ($urandom_range(0, 4) != 0) begin
               queue_cmd(KIND_PUT, CH_NEWLINE, any_index());
               made++;
            end
         end
      end
   endtask

   initial begin : stimulus
      int idle_plan [SEGMENTS];
      logic [ATTR_W-1:0] attr_plan [SEGMENTS];
      idle_plan = '{IDLE_LOW, IDLE_LOW, IDLE_HIGH, IDLE_HIGH, 0, 0};
      attr_plan = '{8'hFF, 8'h00, ATTR_W'($urandom_range(1, 254)), 8'h80,
                    ATTR_W'($urandom_range(1, 254)), 8'hFF};
      model_attr = RESET_ATTR;
      model_col  = 0;
      model_row  = 0;
      blank_screen_model();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_cmd(KIND_READ, 8'h00, 11'd0);
      queue_cmd(KIND_READ, 8'hFF, 11'(CELL_COUNT - 1));
      queue_cmd(KIND_READ, 8'h00, 11'(CELL_COUNT));
      queue_cmd(KIND_READ, 8'hFF, 11'h7FF);
      queue_cmd(KIND_PUT, 8'h48, 11'h7FF);
      queue_cmd(KIND_PUT, 8'h00, 11'd0);
      queue_cmd(KIND_PUT, 8'hFF, 11'h555);
      queue_cmd(KIND_READ, 8'h00, 11'd2);
      queue_cmd(KIND_PUT, CH_BACKSPACE, 11'h2AA);
      queue_cmd(KIND_READ, 8'h00, 11'd2);
      queue_cmd(KIND_READ, 8'h00, 11'd1);
      queue_cmd(KIND_PUT, CH_NEWLINE, 11'd0);
      queue_cmd(KIND_PUT, CH_BACKSPACE, 11'd0);
      queue_cmd(KIND_UNUSED, 8'hFF, 11'h7FF);
      queue_cmd(KIND_UNUSED, 8'h00, 11'd0);
      queue_cmd(KIND_PUT, CH_SPACE, 11'd0);
      queue_cmd(KIND_READ, 8'h00, 11'(COLUMNS));
      queue_cmd(KIND_CLEAR, 8'hFF, 11'h7FF);
      queue_cmd(KIND_READ, 8'h00, 11'd0);
      queue_cmd(KIND_READ, 8'h00, 11'(CELL_COUNT - 1));
      queue_cmd(KIND_PUT, 8'h7F, 11'd0);
      queue_cmd(KIND_READ, 8'h00, 11'd0);
      drain();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         idle_pct = idle_plan[seg];
         write_attribute(attr_plan[seg]);
         build_traffic(SEGMENT_ITEMS);
         drain();
      end

      repeat (COLUMNS + 10) @(posedge clock);
      $display("Checked %0d result beats for %0d commands: %0d puts, %0d reads, %0d clears.",
               checked_count, accepted_count, put_count, read_count, clear_count);
      $display("The screen scrolled %0d times; the attribute was rewritten %0d times.",
               scroll_count, attr_writes);
      if (error_count == 0 && expected_reports.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
